// ----- hw/rtl/ntp_response_offset_processor_core_assert.svh -----
// assertion macros for the ntp response offset processor
`ifndef NTP_RESPONSE_OFFSET_PROCESSOR_CORE_ASSERT_SVH
`define NTP_RESPONSE_OFFSET_PROCESSOR_CORE_ASSERT_SVH

// checked only outside reset
`define NTPRO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NTPRO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ntpro_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ntpro_pkg;

    // stream payload widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 312;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [31:0] ERA_OFFSET_SECONDS = 32'd2208988800;
    localparam logic [29:0] NS_PER_SECOND      = 30'd1000000000;
    localparam logic [10:0] MIN_PACKET_BYTES   = 11'd48;

    // kiss codes, first character in the top byte
    localparam logic [31:0] KISS_DENY = 32'h44454E59;
    localparam logic [31:0] KISS_RSTR = 32'h52535452;
    localparam logic [31:0] KISS_RATE = 32'h52415445;

    localparam logic [4:0] RESET_MIN_POLL = 5'd6;
    localparam logic [4:0] RESET_MAX_POLL = 5'd9;

    // config register indexes
    localparam logic REG_MIN_POLL = 1'b0;
    localparam logic REG_MAX_POLL = 1'b1;

    // func codes
    localparam logic FUNC_REPLY  = 1'b0;
    localparam logic FUNC_ROTATE = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_KISS  = 2'd2;

    // item kind, decoded at the input and carried down the pipe
    localparam logic [2:0] KIND_UPDATE     = 3'd0;
    localparam logic [2:0] KIND_ROTATE     = 3'd1;
    localparam logic [2:0] KIND_SHORT      = 3'd2;
    localparam logic [2:0] KIND_KISS_DROP  = 3'd3;
    localparam logic [2:0] KIND_KISS_RATE  = 3'd4;
    localparam logic [2:0] KIND_KISS_OTHER = 3'd5;

    // stage load enables of the timestamp converter
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } conv_en_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ntp_response_offset_processor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle, set by the six-stage pipe (input, multiply, ns add,
//   differences, sum, result); backpressure stalls stage by stage
// reset: asynchronous active low; clears all valids, poll exponent to 6, flags and
//   stored offset to zero, min/max poll registers to 6 and 9

module ntp_response_offset_processor_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_addr,
    input  wire logic [4:0]                     cfg_wr_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // packet_length[10:0], stratum[18:11], reference_id[50:19],
    // origin_seconds[82:51], origin_fraction[114:83], receive_seconds[146:115],
    // receive_fraction[178:147], transmit_seconds[210:179],
    // transmit_fraction[242:211], arrival_seconds[274:243],
    // arrival_fraction[306:275], zero pad above
    input  wire logic [ntpro_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  wire logic [ntpro_pkg::S_TUSER_W-1:0] s_tuser,
    // output stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // clock_offset_ns[63:0], disable_request[64], rotate_request[65],
    // poll_exponent[70:66], zero pad above
    output logic [ntpro_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [ntpro_pkg::M_TUSER_W-1:0]      m_tuser
);
    import ntpro_pkg::*;

    // pipe stage valids: 0 input, 1 multiply, 2 ns add, 3 differences, 4 sum, 5 result
    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic [5:0] rdy;

    // configuration
    logic [4:0] min_poll_reg;
    logic [4:0] max_poll_reg;

    // stage 0: input register
    logic        func_reg;
    logic [10:0] len_reg;
    logic [7:0]  stratum_reg;
    logic [31:0] refid_reg;
    logic [31:0] stamp_sec_reg  [4];
    logic [31:0] stamp_frac_reg [4];

    // item kind down the pipe
    logic [2:0] kind_dec;
    logic [2:0] kind1_reg;
    logic [2:0] kind2_reg;
    logic [2:0] kind3_reg;
    logic [2:0] kind4_reg;

    // timestamps in ns: 0 origin, 1 receive, 2 transmit, 3 arrival
    conv_en_t    conv_en;
    logic [63:0] stamp_ns [4];

    logic [63:0] diff_a_reg;
    logic [63:0] diff_b_reg;
    logic [63:0] sum_reg;
    logic [63:0] half_sum;

    // block state, shown directly on the output
    logic [4:0]  poll_reg;
    logic [4:0]  poll_next;
    logic        drop_reg;
    logic        drop_next;
    logic        switch_reg;
    logic        switch_next;
    logic [63:0] offset_reg;
    logic [63:0] offset_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic        retire;

    // ready ripples back: a stage takes new data when empty or moving on
    always_comb
    begin
        rdy[5] = !vld_reg[5] || m_tready;
        for (int k = 4; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < 6; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // config writes; the user must write only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_poll_reg <= RESET_MIN_POLL;
            max_poll_reg <= RESET_MAX_POLL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MIN_POLL: min_poll_reg <= cfg_wr_data;
                REG_MAX_POLL: max_poll_reg <= cfg_wr_data;
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            func_reg    <= s_tuser[0];
            len_reg     <= s_tdata[10:0];
            stratum_reg <= s_tdata[18:11];
            refid_reg   <= s_tdata[50:19];
            for (int i = 0; i < 4; i++)
            begin
                stamp_sec_reg[i]  <= s_tdata[51 + 64*i +: 32];
                stamp_frac_reg[i] <= s_tdata[83 + 64*i +: 32];
            end
        end
    end

    // classify the item: rotation, short packet, kiss code or offset update
    always_comb
    begin
        if (func_reg == FUNC_ROTATE)
        begin
            kind_dec = KIND_ROTATE;
        end
        else if (len_reg < MIN_PACKET_BYTES)
        begin
            kind_dec = KIND_SHORT;
        end
        else if (stratum_reg == 8'd0)
        begin
            if (refid_reg == KISS_DENY || refid_reg == KISS_RSTR)
            begin
                kind_dec = KIND_KISS_DROP;
            end
            else if (refid_reg == KISS_RATE)
            begin
                kind_dec = KIND_KISS_RATE;
            end
            else
            begin
                kind_dec = KIND_KISS_OTHER;
            end
        end
        else
        begin
            kind_dec = KIND_UPDATE;
        end
    end

    // stages 1 and 2 live in the converters
    assign conv_en.mul_en = rdy[1];
    assign conv_en.sum_en = rdy[2];

    for (genvar g = 0; g < 4; g++)
    begin : g_conv
        ntpro_stamp_conv u_conv (
            .clk  (clk),
            .en   (conv_en),
            .secs (stamp_sec_reg[g]),
            .frac (stamp_frac_reg[g]),
            .ns   (stamp_ns[g])
        );
    end

    // kind follows stages 1 to 4; stages 3 and 4: (t1 - t0) + (t2 - t3); fits in 64 bits since each t < 2^62
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            kind1_reg <= kind_dec;
        end
        if (rdy[2])
        begin
            kind2_reg <= kind1_reg;
        end
        if (rdy[3])
        begin
            kind3_reg  <= kind2_reg;
            diff_a_reg <= stamp_ns[1] - stamp_ns[0];
            diff_b_reg <= stamp_ns[2] - stamp_ns[3];
        end
        if (rdy[4])
        begin
            kind4_reg <= kind3_reg;
            sum_reg   <= diff_a_reg + diff_b_reg;
        end
    end

    // halve, truncating toward zero: odd negative sums round up by one
    assign half_sum = {sum_reg[63], sum_reg[63:1]} + {63'd0, sum_reg[63] & sum_reg[0]};

    // stage 5: state update as the item retires into the result register
    assign retire = vld_reg[4] && rdy[5];

    always_comb
    begin
        poll_next   = poll_reg;
        drop_next   = drop_reg;
        switch_next = switch_reg;
        offset_next = offset_reg;
        status_next = STATUS_OK;
        case (kind4_reg)
            KIND_ROTATE:
            begin
                poll_next   = min_poll_reg;
                switch_next = 1'b0;
            end
            KIND_SHORT:
            begin
                status_next = STATUS_SHORT;
            end
            KIND_KISS_DROP:
            begin
                status_next = STATUS_KISS;
                drop_next   = 1'b1;
            end
            KIND_KISS_RATE:
            begin
                status_next = STATUS_KISS;
                // back off the poll rate; at the ceiling ask for another server
                if (poll_reg < max_poll_reg)
                begin
                    poll_next = poll_reg + 5'd1;
                end
                else
                begin
                    switch_next = 1'b1;
                end
            end
            KIND_KISS_OTHER:
            begin
                status_next = STATUS_KISS;
            end
            KIND_UPDATE:
            begin
                offset_next = half_sum;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg   <= RESET_MIN_POLL;
            drop_reg   <= 1'b0;
            switch_reg <= 1'b0;
            offset_reg <= '0;
            status_reg <= STATUS_OK;
        end
        else if (retire)
        begin
            poll_reg   <= poll_next;
            drop_reg   <= drop_next;
            switch_reg <= switch_next;
            offset_reg <= offset_next;
            status_reg <= status_next;
        end
    end

    // state only changes when a result is loaded, so it doubles as the payload
    assign m_tdata = {1'b0, poll_reg, switch_reg, drop_reg, offset_reg};
    assign m_tuser = status_reg;

    `include "ntp_response_offset_processor_core_assert.svh"

    `NTPRO_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !m_tvalid, "result valid during reset")
    `NTPRO_ASSERT(a_drop_sticky, drop_reg |=> drop_reg, "disable request dropped")
    `NTPRO_ASSERT(a_rotate_loads_min, (retire && kind4_reg == KIND_ROTATE) |=> (poll_reg == $past(min_poll_reg) && !switch_reg), "rotation did not restore poll state")
    `NTPRO_ASSERT(a_offset_only_on_update, !(retire && kind4_reg == KIND_UPDATE) |=> $stable(offset_reg), "offset changed without an update")
    `NTPRO_ASSERT(a_stall_means_full, !s_tready |-> ((&vld_reg) && !m_tready), "input stalled with room in the pipe")

endmodule

`default_nettype wire

// ----- hw/rtl/ntpro_stamp_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ntpro_stamp_conv (
    input  wire logic              clk,
    input  wire ntpro_pkg::conv_en_t en,
    input  wire logic [31:0]       secs,
    input  wire logic [31:0]       frac,
    output logic      [63:0]       ns
);
    import ntpro_pkg::*;

    logic [31:0] unix_secs;
    logic [61:0] sec_prod_next;
    logic [61:0] sec_prod_reg;
    logic [61:0] frac_prod;
    logic [29:0] frac_ns_next;
    logic [29:0] frac_ns_reg;
    logic [63:0] ns_next;
    logic [63:0] ns_reg;

    // era wrap, then seconds and fraction scaled to nanoseconds
    assign unix_secs     = secs - ERA_OFFSET_SECONDS;
    assign sec_prod_next = 62'(unix_secs) * 62'(NS_PER_SECOND);
    assign frac_prod     = 62'(frac) * 62'(NS_PER_SECOND);
    assign frac_ns_next  = frac_prod[61:32];
    assign ns_next       = {2'b00, sec_prod_reg} + {34'd0, frac_ns_reg};

    always_ff @(posedge clk)
    begin
        if (en.mul_en)
        begin
            sec_prod_reg <= sec_prod_next;
            frac_ns_reg  <= frac_ns_next;
        end
        if (en.sum_en)
        begin
            ns_reg <= ns_next;
        end
    end

    assign ns = ns_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ntpro_pkg::*;

    // one input item as the block sees it, func travels on tuser
    typedef struct packed {
        logic        func;
        logic [10:0] pkt_len;
        logic [7:0]  stratum;
        logic [31:0] refid;
        logic [31:0] org_s;
        logic [31:0] org_f;
        logic [31:0] rx_s;
        logic [31:0] rx_f;
        logic [31:0] tx_s;
        logic [31:0] tx_f;
        logic [31:0] arr_s;
        logic [31:0] arr_f;
    } item_t;

    // one result item: status on tuser, the rest on tdata
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] offset;
        logic        drop;
        logic        rotate;
        logic [4:0]  poll;
    } report_t;

    // directed stimulus row, with an optional hand-written expectation
    typedef struct {
        item_t   it;
        logic    typed;
        report_t rep;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic                 cfg_addr;
    logic [4:0]           cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // own copy of the block state and its poll limits
    logic [4:0]  min_exp;
    logic [4:0]  max_exp;
    logic [4:0]  poll_exp;
    logic        drop_flag;
    logic        switch_flag;
    logic [63:0] stored_offset;

    // expected results in acceptance order
    report_t  pending_reports[$];
    dir_row_t dir_rows[$];

    int items_sent;
    int results_seen;
    int failures;
    int settings_used;
    int n_updates;
    int n_short;
    int n_kiss;
    int n_rotations;
    bit long_hold_done;

    ntp_response_offset_processor_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ntp timestamp to unix nanoseconds, seconds wrap within the 32-bit era
    function automatic logic [63:0] stamp_ns(input logic [31:0] secs, input logic [31:0] frac);
        logic [31:0] unix_secs;
        logic [63:0] nanos;
        unix_secs = secs - ERA_OFFSET_SECONDS;
        nanos = ({32'd0, frac} * 64'(NS_PER_SECOND)) >> 32;
        return {32'd0, unix_secs} * 64'(NS_PER_SECOND) + nanos;
    endfunction

    // advance the state copy by one item and return the result it yields
    function automatic report_t apply_reply(input item_t it);
        report_t r;
        longint  t0;
        longint  t1;
        longint  t2;
        longint  t3;
        longint  sum;
        r.status = STATUS_OK;
        if (it.func == FUNC_ROTATE)
        begin
            // back to the minimum exponent, rotate request served
            poll_exp = min_exp;
            switch_flag = 1'b0;
            n_rotations++;
        end
        else if (it.pkt_len < MIN_PACKET_BYTES)
        begin
            r.status = STATUS_SHORT;
            n_short++;
        end
        else if (it.stratum == 8'd0)
        begin
            r.status = STATUS_KISS;
            n_kiss++;
            if (it.refid == KISS_DENY || it.refid == KISS_RSTR)
                drop_flag = 1'b1;
            else if (it.refid == KISS_RATE)
            begin
                // slow down until the maximum, then ask for another server
                if (poll_exp < max_exp)
                    poll_exp = poll_exp + 5'd1;
                else
                    switch_flag = 1'b1;
            end
        end
        else
        begin
            t0 = stamp_ns(it.org_s, it.org_f);
            t1 = stamp_ns(it.rx_s, it.rx_f);
            t2 = stamp_ns(it.tx_s, it.tx_f);
            t3 = stamp_ns(it.arr_s, it.arr_f);
            // signed division truncates toward zero
            sum = (t1 - t0) + (t2 - t3);
            stored_offset = sum / 2;
            n_updates++;
        end
        r.offset = stored_offset;
        r.drop = drop_flag;
        r.rotate = switch_flag;
        r.poll = poll_exp;
        return r;
    endfunction

    function automatic item_t mk_item(input logic func, input logic [10:0] len,
                                      input logic [7:0] stratum, input logic [31:0] refid);
        item_t it;
        it = '0;
        it.func = func;
        it.pkt_len = len;
        it.stratum = stratum;
        it.refid = refid;
        return it;
    endfunction

    function automatic item_t with_times(input item_t it,
                                         input logic [31:0] os, input logic [31:0] of,
                                         input logic [31:0] rs, input logic [31:0] rf,
                                         input logic [31:0] ts, input logic [31:0] tf,
                                         input logic [31:0] as, input logic [31:0] af);
        item_t r;
        r = it;
        r.org_s = os;
        r.org_f = of;
        r.rx_s = rs;
        r.rx_f = rf;
        r.tx_s = ts;
        r.tx_f = tf;
        r.arr_s = as;
        r.arr_f = af;
        return r;
    endfunction

    function automatic report_t mk_report(input logic [1:0] status, input logic [63:0] offset,
                                          input logic drop, input logic rotate,
                                          input logic [4:0] poll);
        report_t r;
        r.status = status;
        r.offset = offset;
        r.drop = drop;
        r.rotate = rotate;
        r.poll = poll;
        return r;
    endfunction

    function automatic void add_row(input item_t it, input logic typed, input report_t rep);
        dir_row_t row;
        row.it = it;
        row.typed = typed;
        row.rep = rep;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // boundary values for timestamp words
    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return ERA_OFFSET_SECONDS;
            3: return ERA_OFFSET_SECONDS - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // random item: a mix of replies, rotations, short and kiss packets, with varied timestamp sets
    function automatic item_t random_item();
        item_t       it;
        logic [31:0] base;
        int          r;
        it.func = ($urandom_range(0, 99) < 12) ? FUNC_ROTATE : FUNC_REPLY;
        r = $urandom_range(0, 99);
        if (r < 10)
            it.pkt_len = 11'($urandom_range(0, 47));
        else if (r < 15)
            it.pkt_len = 11'd2047;
        else if (r < 20)
            it.pkt_len = MIN_PACKET_BYTES;
        else
            it.pkt_len = 11'($urandom_range(48, 2047));
        it.stratum = ($urandom_range(0, 99) < 35) ? 8'd0 : 8'($urandom_range(1, 255));
        r = $urandom_range(0, 99);
        if (it.stratum != 8'd0 || r >= 55)
            it.refid = $urandom;
        else if (r < 3)
            it.refid = KISS_DENY;
        else if (r < 6)
            it.refid = KISS_RSTR;
        else
            it.refid = KISS_RATE;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            // unrelated timestamps, full range
            it.org_s = $urandom;
            it.rx_s = $urandom;
            it.tx_s = $urandom;
            it.arr_s = $urandom;
        end
        else if (r < 85)
        begin
            // a real exchange: a few seconds apart around one base time
            base = $urandom;
            it.org_s = base;
            it.rx_s = base + 32'($urandom_range(0, 6)) - 32'd3;
            it.tx_s = it.rx_s + 32'($urandom_range(0, 1));
            it.arr_s = base + 32'($urandom_range(0, 2));
        end
        else
        begin
            it.org_s = edge_word();
            it.rx_s = edge_word();
            it.tx_s = edge_word();
            it.arr_s = edge_word();
        end
        if (r >= 85)
        begin
            it.org_f = edge_word();
            it.rx_f = edge_word();
            it.tx_f = edge_word();
            it.arr_f = edge_word();
        end
        else
        begin
            it.org_f = $urandom;
            it.rx_f = $urandom;
            it.tx_f = $urandom;
            it.arr_f = $urandom;
        end
        return it;
    endfunction

    // offer one item, predict its result once the block takes it
    task automatic send_item(input item_t it, input logic typed, input report_t typed_rep);
        logic [S_TDATA_W-1:0] word;
        report_t              predicted;
        int                   gap;
        word = {5'd0, it.arr_f, it.arr_s, it.tx_f, it.tx_s, it.rx_f, it.rx_s,
                it.org_f, it.org_s, it.refid, it.stratum, it.pkt_len};
        // a stretch of back-to-back items with no gaps
        gap = (items_sent >= 450 && items_sent < 550) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= word;
        s_tuser <= it.func;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_reply(it);
        // hand-written rows still move the state copy along
        pending_reports.insert(pending_reports.size(), typed ? typed_rep : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // drain every expected result, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // both poll limits in back-to-back writes, block idle
    task automatic write_poll_limits(input logic [4:0] lo, input logic [4:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_MIN_POLL;
        cfg_wr_data <= lo;
        @(negedge clk);
        cfg_addr <= REG_MAX_POLL;
        cfg_wr_data <= hi;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        min_exp = lo;
        max_exp = hi;
        settings_used++;
    endtask

    function automatic void note_failure(input string what, input report_t want,
                                         input report_t got);
        failures++;
        if (failures <= 10)
            $display("%s at result %0d: expected status %0d offset %0d drop %0b rotate %0b poll %0d",
                     what, results_seen, want.status, $signed(want.offset), want.drop,
                     want.rotate, want.poll);
        if (failures <= 10)
            $display("    got status %0d offset %0d drop %0b rotate %0b poll %0d",
                     got.status, $signed(got.offset), got.drop, got.rotate, got.poll);
    endfunction

    // result side: random stalls, one long hold-off, one stall-free stretch
    initial
    begin : result_side
        report_t got;
        report_t want;
        int      stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!long_hold_done && results_seen >= 300)
            begin
                // long back-pressure, the sender keeps offering until the pipe is full
                m_tready <= 1'b0;
                repeat (60) @(negedge clk);
                long_hold_done = 1'b1;
            end
            stall = (results_seen >= 800 && results_seen < 900) ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.status = m_tuser[1:0];
            got.offset = m_tdata[63:0];
            got.drop = m_tdata[64];
            got.rotate = m_tdata[65];
            got.poll = m_tdata[70:66];
            if (pending_reports.size() == 0)
                note_failure("unexpected item", '0, got);
            else
            begin
                want = pending_reports.pop_front();
                if (got.status !== want.status || got.offset !== want.offset ||
                    got.drop !== want.drop || got.rotate !== want.rotate ||
                    got.poll !== want.poll)
                    note_failure("mismatch", want, got);
            end
            results_seen++;
            @(negedge clk);
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", pending_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int          p;
        int          i;
        logic [4:0]  lo;
        logic [4:0]  hi;
        logic [31:0] era;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_MIN_POLL;
        cfg_wr_data = 5'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        era = ERA_OFFSET_SECONDS;
        // state copy at reset
        min_exp = RESET_MIN_POLL;
        max_exp = RESET_MAX_POLL;
        poll_exp = RESET_MIN_POLL;
        drop_flag = 1'b0;
        switch_flag = 1'b0;
        stored_offset = 64'd0;

        // rotation right after reset, reply fields ignored
        add_row(with_times(mk_item(FUNC_ROTATE, 11'd2047, 8'hFF, 32'hFFFF_FFFF),
                           '1, '1, '1, '1, '1, '1, '1, '1),
                1'b1, mk_report(STATUS_OK, 64'd0, 1'b0, 1'b0, 5'd6));
        // empty datagram and one byte short of a header, short wins over kiss
        add_row(mk_item(FUNC_REPLY, 11'd0, 8'hFF, 32'hFFFF_FFFF),
                1'b1, mk_report(STATUS_SHORT, 64'd0, 1'b0, 1'b0, 5'd6));
        add_row(mk_item(FUNC_REPLY, 11'd47, 8'd0, KISS_RATE),
                1'b1, mk_report(STATUS_SHORT, 64'd0, 1'b0, 1'b0, 5'd6));
        // unknown kiss code leaves everything alone
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, 32'd0),
                1'b1, mk_report(STATUS_KISS, 64'd0, 1'b0, 1'b0, 5'd6));
        // rate kiss climbs 6 -> 9, then turns into a rotate request
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, KISS_RATE),
                1'b1, mk_report(STATUS_KISS, 64'd0, 1'b0, 1'b0, 5'd7));
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, KISS_RATE),
                1'b1, mk_report(STATUS_KISS, 64'd0, 1'b0, 1'b0, 5'd8));
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, KISS_RATE),
                1'b1, mk_report(STATUS_KISS, 64'd0, 1'b0, 1'b0, 5'd9));
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, KISS_RATE),
                1'b1, mk_report(STATUS_KISS, 64'd0, 1'b0, 1'b1, 5'd9));
        add_row(mk_item(FUNC_REPLY, 11'd2047, 8'd0, KISS_RATE),
                1'b1, mk_report(STATUS_KISS, 64'd0, 1'b0, 1'b1, 5'd9));
        // rotation clears the rotate request and restores the minimum
        add_row(mk_item(FUNC_ROTATE, 11'd0, 8'd0, 32'd0),
                1'b1, mk_report(STATUS_OK, 64'd0, 1'b0, 1'b0, 5'd6));
        // all four stamps at the unix epoch
        add_row(with_times(mk_item(FUNC_REPLY, 11'd2047, 8'd255, 32'd0),
                           era, 0, era, 0, era, 0, era, 0),
                1'b1, mk_report(STATUS_OK, 64'd0, 1'b0, 1'b0, 5'd6));
        // sum of -3 ns halves to -1, sum of +1 ns truncates to 0
        add_row(with_times(mk_item(FUNC_REPLY, 11'd48, 8'd1, 32'd0),
                           era, 32'd13, era, 0, era, 0, era, 0),
                1'b1, mk_report(STATUS_OK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 5'd6));
        add_row(with_times(mk_item(FUNC_REPLY, 11'd48, 8'd1, 32'd0),
                           era, 0, era, 32'd5, era, 0, era, 0),
                1'b1, mk_report(STATUS_OK, 64'd0, 1'b0, 1'b0, 5'd6));
        // largest positive and most negative offsets
        add_row(with_times(mk_item(FUNC_REPLY, 11'd48, 8'd1, 32'd0),
                           era, 0, era - 1, '1, era - 1, '1, era, 0), 1'b0, '0);
        add_row(with_times(mk_item(FUNC_REPLY, 11'd48, 8'd1, 32'd0),
                           era - 1, '1, era, 0, era, 0, era - 1, '1), 1'b0, '0);
        // raw seconds at both ends of the word
        add_row(with_times(mk_item(FUNC_REPLY, 11'd1500, 8'd2, 32'h1234_5678),
                           0, '1, '1, 0, 0, '1, '1, 0), 1'b0, '0);
        // short packet and unknown kiss code keep the stored offset
        add_row(mk_item(FUNC_REPLY, 11'd47, 8'd3, 32'd0), 1'b0, '0);
        add_row(mk_item(FUNC_REPLY, 11'd100, 8'd0, 32'h4142_4344), 1'b0, '0);
        // drop requests, and a rotation that must not clear them
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, KISS_DENY), 1'b0, '0);
        add_row(mk_item(FUNC_REPLY, 11'd48, 8'd0, KISS_RSTR), 1'b0, '0);
        add_row(mk_item(FUNC_ROTATE, 11'd0, 8'd0, 32'd0), 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].rep);

        // random phases across poll limit settings, extremes first
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: begin lo = 5'd0;  hi = 5'd31; end
                1: begin lo = 5'd31; hi = 5'd0;  end  // minimum above maximum
                2: begin lo = 5'd0;  hi = 5'd0;  end
                3: begin lo = 5'd31; hi = 5'd31; end
                default:
                begin
                    lo = 5'($urandom_range(0, 31));
                    hi = 5'($urandom_range(0, 31));
                end
            endcase
            wait_idle();
            write_poll_limits(lo, hi);
            for (i = 0; i < 200; i++)
                send_item(random_item(), 1'b0, '0);
        end

        wait_idle();
        $display("run: %0d items, %0d results checked over %0d poll limit settings",
                 items_sent, results_seen, settings_used);
        $display("mix: %0d offset updates, %0d short, %0d kiss, %0d rotations",
                 n_updates, n_short, n_kiss, n_rotations);
        if (failures == 0 && pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
